FILE: rtl/core/tcs_pkg.sv
// ----------------------------------------------------------------------------
// tcs_pkg
// Shared constants of the tetrahedron circumsphere unit.
// ----------------------------------------------------------------------------
package tcs_pkg;

  localparam int NUM_AXES    = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int OUT_DEPTH   = 2;

endpackage

FILE: rtl/core/tcs_if.sv
// ----------------------------------------------------------------------------
// tcs_if
// Valid/ready channels of the circumsphere unit: vertex items in, sphere out.
// ----------------------------------------------------------------------------
interface tcs_in_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] p0_x;
  logic signed [COORD_BITS-1:0] p0_y;
  logic signed [COORD_BITS-1:0] p0_z;
  logic signed [COORD_BITS-1:0] p1_x;
  logic signed [COORD_BITS-1:0] p1_y;
  logic signed [COORD_BITS-1:0] p1_z;
  logic signed [COORD_BITS-1:0] p2_x;
  logic signed [COORD_BITS-1:0] p2_y;
  logic signed [COORD_BITS-1:0] p2_z;
  logic signed [COORD_BITS-1:0] p3_x;
  logic signed [COORD_BITS-1:0] p3_y;
  logic signed [COORD_BITS-1:0] p3_z;

  modport source (
    output valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    output p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    input  ready
  );
  modport sink (
    input  valid, p0_x, p0_y, p0_z, p1_x, p1_y, p1_z,
    input  p2_x, p2_y, p2_z, p3_x, p3_y, p3_z,
    output ready
  );
endinterface

interface tcs_out_if #(
  parameter int COORD_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS-1:0] sphere_radius;
  logic                         degenerate;

  modport source (
    output valid, center_x, center_y, center_z, sphere_radius, degenerate,
    input  ready
  );
  modport sink (
    input  valid, center_x, center_y, center_z, sphere_radius, degenerate,
    output ready
  );
endinterface

FILE: rtl/core/tcs_fifo.sv
// ----------------------------------------------------------------------------
// tcs_fifo
// Small register queue; room and valid come from the registered count.
// ----------------------------------------------------------------------------
module tcs_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  output logic             room,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] dout
);
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CNTW-1:0]  count;

  assign room  = (count != CNTW'(DEPTH));
  assign valid = (count != '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end
endmodule

FILE: rtl/core/tcs_front.sv
// ----------------------------------------------------------------------------
// tcs_front
// Edge vectors, cofactors and the determinants; flags coplanar items and
// hands division operands to the queue.
// ----------------------------------------------------------------------------
module tcs_front #(
  parameter  int COORD_BITS = 32,
  localparam int NW  = 4*COORD_BITS + 6,
  localparam int DNW = 3*COORD_BITS + 6
) (
  input  logic                         clk,
  input  logic                         rst,
  tcs_in_if.sink                       in_ch,
  input  logic                         room,
  output logic                         f_valid,
  output logic signed [COORD_BITS-1:0] f_p0   [tcs_pkg::NUM_AXES],
  output logic        [NW-1:0]         f_nmag [tcs_pkg::NUM_AXES],
  output logic        [DNW-1:0]        f_dv,
  output logic        [tcs_pkg::NUM_AXES-1:0] f_neg,
  output logic                         f_degen
);
  import tcs_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int DW = W + 1;
  localparam int PW = 2*DW;
  localparam int BW = 2*W + 2;
  localparam int CW = 2*W + 3;
  localparam int H  = W + 2;

  logic       en;
  logic [5:0] vld;

  logic signed [W-1:0]  pin   [4][NUM_AXES];
  logic signed [W-1:0]  p0_s  [6][NUM_AXES];
  logic signed [DW-1:0] d1    [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] sq2   [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] pa2   [NUM_AXES][NUM_AXES];
  logic signed [PW-1:0] pb2   [NUM_AXES][NUM_AXES];
  logic signed [DW-1:0] d2x   [NUM_AXES];
  logic        [BW-1:0] b3    [NUM_AXES];
  logic signed [CW-1:0] c3    [NUM_AXES][NUM_AXES];
  logic signed [DW-1:0] d3x   [NUM_AXES];
  logic signed [H:0]    clx   [NUM_AXES][NUM_AXES];
  logic signed [W:0]    chi   [NUM_AXES][NUM_AXES];
  logic signed [H:0]    blx   [NUM_AXES];
  logic signed [W:0]    bhx   [NUM_AXES];
  logic signed [DW+H:0]    dl4 [NUM_AXES];
  logic signed [DW+W:0]    dh4 [NUM_AXES];
  logic signed [2*H+1:0]   ll4 [NUM_AXES][NUM_AXES];
  logic signed [H+W+1:0]   lh4 [NUM_AXES][NUM_AXES];
  logic signed [W+H+1:0]   hl4 [NUM_AXES][NUM_AXES];
  logic signed [2*W+1:0]   hh4 [NUM_AXES][NUM_AXES];
  logic signed [DNW-1:0] dt5  [NUM_AXES];
  logic signed [NW-1:0]  nt5  [NUM_AXES][NUM_AXES];
  logic signed [DNW-1:0] den6;
  logic signed [NW-1:0]  num6 [NUM_AXES];
  logic        [DNW-1:0] aden;
  logic        [NW-1:0]  anum [NUM_AXES];

  assign en          = !f_valid || room;
  assign in_ch.ready = en;

  always_comb begin
    pin[0][0] = in_ch.p0_x; pin[0][1] = in_ch.p0_y; pin[0][2] = in_ch.p0_z;
    pin[1][0] = in_ch.p1_x; pin[1][1] = in_ch.p1_y; pin[1][2] = in_ch.p1_z;
    pin[2][0] = in_ch.p2_x; pin[2][1] = in_ch.p2_y; pin[2][2] = in_ch.p2_z;
    pin[3][0] = in_ch.p3_x; pin[3][1] = in_ch.p3_y; pin[3][2] = in_ch.p3_z;
  end

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      blx[i] = $signed({1'b0, b3[i][H-1:0]});
      bhx[i] = $signed({1'b0, b3[i][BW-1:H]});
      for (int k = 0; k < NUM_AXES; k++) begin
        clx[i][k] = $signed({1'b0, c3[i][k][H-1:0]});
        chi[i][k] = $signed(c3[i][k][CW-1:H]);
      end
    end
  end

  always_comb begin
    aden = den6[DNW-1] ? DNW'(-den6) : DNW'(den6);
    for (int k = 0; k < NUM_AXES; k++) begin
      anum[k] = num6[k][NW-1] ? NW'(-num6[k]) : NW'(num6[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld     <= '0;
      f_valid <= 1'b0;
    end else if (en) begin
      vld     <= {vld[4:0], in_ch.valid};
      f_valid <= vld[5];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        int i1, i2;
        i1 = (i == 2) ? 0 : i + 1;
        i2 = (i == 0) ? 2 : i - 1;
        d2x[i] <= d1[i][0];
        d3x[i] <= d2x[i];
        b3[i]  <= BW'(sq2[i][0]) + BW'(sq2[i][1]) + BW'(sq2[i][2]);
        dl4[i] <= d3x[i] * clx[i][0];
        dh4[i] <= d3x[i] * chi[i][0];
        dt5[i] <= (DNW'(dh4[i]) <<< H) + DNW'(dl4[i]);
        for (int k = 0; k < NUM_AXES; k++) begin
          int k1, k2;
          k1 = (k == 2) ? 0 : k + 1;
          k2 = (k == 0) ? 2 : k - 1;
          d1[i][k]  <= DW'(pin[i+1][k]) - DW'(pin[0][k]);
          sq2[i][k] <= d1[i][k] * d1[i][k];
          pa2[i][k] <= d1[i1][k1] * d1[i2][k2];
          pb2[i][k] <= d1[i1][k2] * d1[i2][k1];
          c3[i][k]  <= CW'(pa2[i][k]) - CW'(pb2[i][k]);
          ll4[i][k] <= blx[i] * clx[i][k];
          lh4[i][k] <= blx[i] * chi[i][k];
          hl4[i][k] <= bhx[i] * clx[i][k];
          hh4[i][k] <= bhx[i] * chi[i][k];
          nt5[i][k] <= (NW'(hh4[i][k]) <<< (2*H))
                     + ((NW'(lh4[i][k]) + NW'(hl4[i][k])) <<< H)
                     + NW'(ll4[i][k]);
        end
      end
      den6 <= dt5[0] + dt5[1] + dt5[2];
      for (int k = 0; k < NUM_AXES; k++) begin
        num6[k]    <= nt5[0][k] + nt5[1][k] + nt5[2][k];
        f_nmag[k]  <= anum[k] + NW'(aden);
        f_neg[k]   <= num6[k][NW-1] ^ den6[DNW-1];
        p0_s[0][k] <= pin[0][k];
        for (int s = 1; s < 6; s++) begin
          p0_s[s][k] <= p0_s[s-1][k];
        end
        f_p0[k] <= p0_s[5][k];
      end
      f_dv    <= {aden[DNW-2:0], 1'b0};
      f_degen <= (den6 == '0);
    end
  end
endmodule

FILE: rtl/core/tcs_back.sv
// ----------------------------------------------------------------------------
// tcs_back
// Rounded center offsets by a bit-per-stage divider, saturation, and the
// rounded radius by a bit-per-stage square root.
// ----------------------------------------------------------------------------
module tcs_back #(
  parameter  int COORD_BITS = 32,
  localparam int NW  = 4*COORD_BITS + 6,
  localparam int DNW = 3*COORD_BITS + 6
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_valid,
  output logic                         q_pop,
  input  logic signed [COORD_BITS-1:0] q_p0   [tcs_pkg::NUM_AXES],
  input  logic        [NW-1:0]         q_nmag [tcs_pkg::NUM_AXES],
  input  logic        [DNW-1:0]        q_dv,
  input  logic        [tcs_pkg::NUM_AXES-1:0] q_neg,
  input  logic                         q_degen,
  input  logic                         room,
  output logic                         o_valid,
  output logic signed [COORD_BITS-1:0] o_center [tcs_pkg::NUM_AXES],
  output logic        [COORD_BITS-1:0] o_radius,
  output logic                         o_degen
);
  import tcs_pkg::*;

  localparam int W  = COORD_BITS;
  localparam int SQ = W + 2;
  localparam int RW = 2*W + 5;
  localparam logic signed [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

  logic en;

  // divider pipeline, index 0 is the load stage
  logic                  dvld   [0:W];
  logic [NW-1:0]         rem_s  [0:W][NUM_AXES];
  logic [W-1:0]          quo_s  [0:W][NUM_AXES];
  logic [DNW-1:0]        dvr_s  [0:W];
  logic signed [W-1:0]   dp0_s  [0:W][NUM_AXES];
  logic [NUM_AXES-1:0]   neg_s  [0:W];
  logic [NUM_AXES-1:0]   big_s  [0:W];
  logic                  ddg_s  [0:W];
  logic [NW-1:0]         tdiv   [1:W][NUM_AXES];
  logic                  take_d [1:W][NUM_AXES];

  // center stage
  logic                  c_valid;
  logic signed [W-1:0]   c_center [NUM_AXES];
  logic [2*W-1:0]        c_sq     [NUM_AXES];
  logic                  c_rsat;
  logic                  c_degen;
  logic signed [W+1:0]   csum     [NUM_AXES];
  logic signed [W-1:0]   cnext    [NUM_AXES];

  // square root pipeline, index 0 holds the sum of squares
  logic                  rvld   [0:SQ];
  logic [SQ-1:0]         res_s  [0:SQ];
  logic [RW-1:0]         rm_s   [0:SQ];
  logic signed [W-1:0]   rc_s   [0:SQ][NUM_AXES];
  logic                  rsat_s [0:SQ];
  logic                  rdg_s  [0:SQ];
  logic [RW-1:0]         tsq    [1:SQ];
  logic                  take_r [1:SQ];
  logic [SQ:0]           rfin;

  assign en    = !o_valid || room;
  assign q_pop = en && q_valid;

  always_comb begin
    for (int s = 1; s <= W; s++) begin
      for (int k = 0; k < NUM_AXES; k++) begin
        tdiv[s][k]   = NW'(dvr_s[s-1]) << (W - s);
        take_d[s][k] = (rem_s[s-1][k] >= tdiv[s][k]);
      end
    end
    for (int t = 1; t <= SQ; t++) begin
      tsq[t]    = (RW'(res_s[t-1]) << (SQ - t + 1)) + (RW'(1) << (2*(SQ - t)));
      take_r[t] = (tsq[t] <= rm_s[t-1]);
    end
    for (int k = 0; k < NUM_AXES; k++) begin
      csum[k] = neg_s[W][k] ? (W+2)'(dp0_s[W][k]) - $signed({2'b00, quo_s[W][k]})
                            : (W+2)'(dp0_s[W][k]) + $signed({2'b00, quo_s[W][k]});
      if (big_s[W][k]) begin
        cnext[k] = neg_s[W][k] ? SMIN : SMAX;
      end else if (csum[k] > (W+2)'(SMAX)) begin
        cnext[k] = SMAX;
      end else if (csum[k] < (W+2)'(SMIN)) begin
        cnext[k] = SMIN;
      end else begin
        cnext[k] = csum[k][W-1:0];
      end
    end
    rfin = (rm_s[SQ] > RW'(res_s[SQ])) ? (SQ+1)'(res_s[SQ]) + 1'b1 : (SQ+1)'(res_s[SQ]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= W; s++) dvld[s] <= 1'b0;
      for (int t = 0; t <= SQ; t++) rvld[t] <= 1'b0;
      c_valid <= 1'b0;
      o_valid <= 1'b0;
    end else if (en) begin
      dvld[0] <= q_valid;
      for (int s = 1; s <= W; s++) dvld[s] <= dvld[s-1];
      c_valid <= dvld[W];
      rvld[0] <= c_valid;
      for (int t = 1; t <= SQ; t++) rvld[t] <= rvld[t-1];
      o_valid <= rvld[SQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dvr_s[0] <= q_dv;
      neg_s[0] <= q_neg;
      ddg_s[0] <= q_degen;
      for (int k = 0; k < NUM_AXES; k++) begin
        rem_s[0][k] <= q_nmag[k];
        quo_s[0][k] <= '0;
        dp0_s[0][k] <= q_p0[k];
        big_s[0][k] <= (q_nmag[k] >= (NW'(q_dv) << W));
      end
      for (int s = 1; s <= W; s++) begin
        dvr_s[s] <= dvr_s[s-1];
        neg_s[s] <= neg_s[s-1];
        big_s[s] <= big_s[s-1];
        ddg_s[s] <= ddg_s[s-1];
        for (int k = 0; k < NUM_AXES; k++) begin
          dp0_s[s][k] <= dp0_s[s-1][k];
          rem_s[s][k] <= take_d[s][k] ? rem_s[s-1][k] - tdiv[s][k] : rem_s[s-1][k];
          quo_s[s][k] <= quo_s[s-1][k] | (W'(take_d[s][k]) << (W - s));
        end
      end

      for (int k = 0; k < NUM_AXES; k++) begin
        c_center[k] <= cnext[k];
        c_sq[k]     <= quo_s[W][k] * quo_s[W][k];
      end
      c_rsat  <= |big_s[W];
      c_degen <= ddg_s[W];

      res_s[0]  <= '0;
      rm_s[0]   <= RW'(c_sq[0]) + RW'(c_sq[1]) + RW'(c_sq[2]);
      rsat_s[0] <= c_rsat;
      rdg_s[0]  <= c_degen;
      for (int k = 0; k < NUM_AXES; k++) rc_s[0][k] <= c_center[k];
      for (int t = 1; t <= SQ; t++) begin
        res_s[t]  <= res_s[t-1] | (SQ'(take_r[t]) << (SQ - t));
        rm_s[t]   <= take_r[t] ? rm_s[t-1] - tsq[t] : rm_s[t-1];
        rsat_s[t] <= rsat_s[t-1];
        rdg_s[t]  <= rdg_s[t-1];
        for (int k = 0; k < NUM_AXES; k++) rc_s[t][k] <= rc_s[t-1][k];
      end

      o_degen <= rdg_s[SQ];
      for (int k = 0; k < NUM_AXES; k++) begin
        o_center[k] <= rdg_s[SQ] ? '0 : rc_s[SQ][k];
      end
      if (rdg_s[SQ]) begin
        o_radius <= '0;
      end else if (rsat_s[SQ] || (rfin[SQ:W] != '0)) begin
        o_radius <= '1;
      end else begin
        o_radius <= rfin[W-1:0];
      end
    end
  end
endmodule

FILE: rtl/core/tetrahedron_circumsphere_unit.sv
// ----------------------------------------------------------------------------
// tetrahedron_circumsphere_unit
// Circumcenter and circumradius of one tetrahedron per item.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries the four vertices p0..p3 (signed fixed point, COORD_BITS
//   wide); an item is taken when valid and ready are both high. out_ch returns
//   one item per input: the saturated center, the rounded radius and the
//   degenerate flag (coplanar vertices, all other fields zero).
//   Throughput is one item per cycle while neither side stalls. Items pass
//   through 7 determinant stages, the queue, a divider retiring one
//   quotient bit per stage (COORD_BITS stages), the center stage,
//   COORD_BITS + 2 square root stages and the output queue.
//   The front and back pipelines each advance as a whole; a 4-entry queue
//   between them and a 2-entry output queue let either side stall alone.
//   When out_ch.ready is low the output queue fills, the back halts, then the
//   middle queue fills and in_ch.ready falls. Nothing is lost or repeated.
//   Reset (rst, synchronous) empties both queues and all pipeline valids.
// ----------------------------------------------------------------------------
module tetrahedron_circumsphere_unit #(
  parameter int COORD_BITS = 32
) (
  input  logic       clk,
  input  logic       rst,
  tcs_in_if.sink     in_ch,
  tcs_out_if.source  out_ch
);
  import tcs_pkg::*;

  localparam int W   = COORD_BITS;
  localparam int NW  = 4*W + 6;
  localparam int DNW = 3*W + 6;
  localparam int QW  = NUM_AXES*W + NUM_AXES*NW + DNW + NUM_AXES + 1;
  localparam int OW  = 4*W + 1;

  logic                f_valid;
  logic signed [W-1:0] f_p0   [NUM_AXES];
  logic [NW-1:0]       f_nmag [NUM_AXES];
  logic [DNW-1:0]      f_dv;
  logic [NUM_AXES-1:0] f_neg;
  logic                f_degen;
  logic                q_room;
  logic                q_push;
  logic [QW-1:0]       q_din;
  logic                q_valid;
  logic                q_pop;
  logic [QW-1:0]       q_dout;
  logic signed [W-1:0] b_p0   [NUM_AXES];
  logic [NW-1:0]       b_nmag [NUM_AXES];
  logic [DNW-1:0]      b_dv;
  logic [NUM_AXES-1:0] b_neg;
  logic                b_degen;
  logic                o_room;
  logic                o_valid;
  logic signed [W-1:0] o_center [NUM_AXES];
  logic [W-1:0]        o_radius;
  logic                o_degen;
  logic                o_push;
  logic [OW-1:0]       o_din;
  logic                of_pop;
  logic [OW-1:0]       of_dout;

  tcs_front #(.COORD_BITS(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .room    (q_room),
    .f_valid (f_valid),
    .f_p0    (f_p0),
    .f_nmag  (f_nmag),
    .f_dv    (f_dv),
    .f_neg   (f_neg),
    .f_degen (f_degen)
  );

  assign q_push = f_valid && q_room;
  assign q_din  = {f_p0[0], f_p0[1], f_p0[2], f_nmag[0], f_nmag[1], f_nmag[2],
                   f_dv, f_neg, f_degen};

  tcs_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .room  (q_room),
    .pop   (q_pop),
    .valid (q_valid),
    .dout  (q_dout)
  );

  assign {b_p0[0], b_p0[1], b_p0[2], b_nmag[0], b_nmag[1], b_nmag[2],
          b_dv, b_neg, b_degen} = q_dout;

  tcs_back #(.COORD_BITS(W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_p0     (b_p0),
    .q_nmag   (b_nmag),
    .q_dv     (b_dv),
    .q_neg    (b_neg),
    .q_degen  (b_degen),
    .room     (o_room),
    .o_valid  (o_valid),
    .o_center (o_center),
    .o_radius (o_radius),
    .o_degen  (o_degen)
  );

  assign o_push = o_valid && o_room;
  assign o_din  = {o_center[0], o_center[1], o_center[2], o_radius, o_degen};

  tcs_fifo #(.WIDTH(OW), .DEPTH(OUT_DEPTH)) u_out_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (o_push),
    .din   (o_din),
    .room  (o_room),
    .pop   (of_pop),
    .valid (out_ch.valid),
    .dout  (of_dout)
  );

  assign of_pop = out_ch.valid && out_ch.ready;
  assign {out_ch.center_x, out_ch.center_y, out_ch.center_z,
          out_ch.sphere_radius, out_ch.degenerate} = of_dout;
endmodule
